[design/ps2mc_pkg.sv]
// Shared types and constants for the PS/2 mouse packet cursor block.
`default_nettype none
package ps2mc_pkg;

  localparam int COORD_BITS_DEF = 12;

  localparam int SIZE_BITS = 13;
  localparam int GAIN_BITS = 4;
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MOTION_GAIN   = 2'd2;

  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd800;
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd600;
  localparam logic [GAIN_BITS-1:0] MOTION_GAIN_RESET   = 4'd2;

  localparam int POS_X_RESET = 400;
  localparam int POS_Y_RESET = 300;

  // Header byte fields
  localparam logic [7:0] HDR_SYNC  = 8'h08;
  localparam logic [7:0] HDR_OVF   = 8'hC0;
  localparam logic [7:0] HDR_XSIGN = 8'h10;
  localparam logic [7:0] HDR_YSIGN = 8'h20;

  typedef struct packed {
    logic [SIZE_BITS-1:0] screen_width;
    logic [SIZE_BITS-1:0] screen_height;
    logic [GAIN_BITS-1:0] motion_gain;
  } cfg_t;

  // One framed, non-overflowed packet, present for one cycle
  typedef struct packed {
    logic              valid;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic [2:0]        buttons;
  } pkt_t;

endpackage
`default_nettype wire

[design/ps2mc_if.sv]
// Channel interfaces: received bytes, cursor results and configuration writes.
`default_nettype none
interface ps2mc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2mc_cursor_if #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;
  logic [2:0]            buttons;
  modport source (output valid, output cursor_x, output cursor_y, output buttons, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, input buttons, output ready);
endinterface

interface ps2mc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ps2mc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [ps2mc_pkg::SIZE_BITS-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/ps2_mouse_packet_cursor_core.sv]
// PS/2 mouse packet decoder: frames received bytes into three-byte packets, skips
// bytes without the sync bit where a packet should start, drops packets with an
// overflow bit, scales the X/Y deltas by the motion gain and moves a cursor clamped
// to the configured screen (Y grows downward). Accepts one byte per clock cycle
// unless stalled; each byte sits in the input register and the single update stage
// loads the result register from it once that register is free, so a result is
// presented after its third byte has passed through the input register. The result
// register frees up in the same cycle it is taken, so stalls only hold bytes when a
// finished result is still waiting. Configuration writes take effect on the next
// packet; the stored position is clamped to a new screen size only then.
`default_nettype none
module ps2_mouse_packet_cursor_core #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ps2mc_byte_if.sink     rx,
  ps2mc_cursor_if.source res,
  ps2mc_cfg_if.sink      cfg
);

  ps2mc_pkg::cfg_t regs;
  ps2mc_pkg::pkt_t pkt;
  logic            take;

  ps2mc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ps2mc_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .pkt  (pkt)
  );

  ps2mc_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .pkt  (pkt),
    .take (take),
    .res  (res)
  );

endmodule
`default_nettype wire

[design/ps2mc_cfg.sv]
// Configuration registers: screen size and motion gain.
`default_nettype none
module ps2mc_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  ps2mc_cfg_if.sink        cfg,
  output ps2mc_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.screen_width  <= ps2mc_pkg::SCREEN_WIDTH_RESET;
      regs.screen_height <= ps2mc_pkg::SCREEN_HEIGHT_RESET;
      regs.motion_gain   <= ps2mc_pkg::MOTION_GAIN_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ps2mc_pkg::REG_SCREEN_WIDTH:  regs.screen_width  <= cfg.data;
        ps2mc_pkg::REG_SCREEN_HEIGHT: regs.screen_height <= cfg.data;
        ps2mc_pkg::REG_MOTION_GAIN:   regs.motion_gain   <= cfg.data[ps2mc_pkg::GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/ps2mc_frame.sv]
// Input byte register and three-byte packet framer.
`default_nettype none
module ps2mc_frame (
  input  wire logic       clk,
  input  wire logic       rst,
  ps2mc_byte_if.sink      rx,
  input  wire logic       take,
  output ps2mc_pkg::pkt_t pkt
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_XBYTE  = 2'd1;
  localparam logic [1:0] PH_YBYTE  = 2'd2;

  logic       in_valid;
  logic [7:0] in_byte;
  logic [1:0] phase;
  logic [7:0] header_byte;
  logic [7:0] x_delta_byte;
  logic       adv;

  assign adv      = in_valid && take;
  assign rx.ready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_byte  <= 8'h00;
      x_delta_byte <= 8'h00;
    end else if (adv) begin
      unique case (phase)
        PH_XBYTE: begin
          x_delta_byte <= in_byte;
          phase        <= PH_YBYTE;
        end
        PH_YBYTE: begin
          phase <= PH_HEADER;
        end
        default: begin
          // only a byte with the sync bit can open a packet
          if ((in_byte & ps2mc_pkg::HDR_SYNC) != 8'h00) begin
            header_byte <= in_byte;
            phase       <= PH_XBYTE;
          end else begin
            phase <= PH_HEADER;
          end
        end
      endcase
    end
  end

  always_comb begin
    pkt.valid   = adv && (phase == PH_YBYTE) && ((header_byte & ps2mc_pkg::HDR_OVF) == 8'h00);
    pkt.dx      = $signed({(header_byte & ps2mc_pkg::HDR_XSIGN) != 8'h00, x_delta_byte});
    pkt.dy      = $signed({(header_byte & ps2mc_pkg::HDR_YSIGN) != 8'h00, in_byte});
    pkt.buttons = header_byte[2:0];
  end

endmodule
`default_nettype wire

[design/ps2mc_cursor.sv]
// Cursor position update, clamp and result register.
`default_nettype none
module ps2mc_cursor #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ps2mc_pkg::cfg_t regs,
  input  wire ps2mc_pkg::pkt_t pkt,
  output logic                 take,
  ps2mc_cursor_if.source       res
);

  localparam int SUM_BITS = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
  localparam int unsigned CAP = 32'd1 << COORD_BITS;

  logic                        out_valid;
  logic [COORD_BITS-1:0]       pos_x;
  logic [COORD_BITS-1:0]       pos_y;
  logic [2:0]                  buttons;
  logic [COORD_BITS-1:0]       lim_x;
  logic [COORD_BITS-1:0]       lim_y;
  logic signed [13:0]          prod_x;
  logic signed [13:0]          prod_y;
  logic signed [SUM_BITS-1:0]  sum_x;
  logic signed [SUM_BITS-1:0]  sum_y;
  logic [COORD_BITS-1:0]       pos_x_next;
  logic [COORD_BITS-1:0]       pos_y_next;

  function automatic logic [COORD_BITS-1:0] limit_of(input logic [ps2mc_pkg::SIZE_BITS-1:0] size);
    logic [COORD_BITS-1:0] lim;
    if (size == '0) begin
      lim = '0;
    end else if (32'(size) > CAP) begin
      lim = '1;
    end else begin
      lim = COORD_BITS'(size - 13'd1);
    end
    return lim;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_to(input logic signed [SUM_BITS-1:0] v,
                                                     input logic [COORD_BITS-1:0] hi);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > SUM_BITS'($signed({1'b0, hi}))) begin
      r = hi;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  assign take = !out_valid || res.ready;

  always_comb begin
    lim_x      = limit_of(regs.screen_width);
    lim_y      = limit_of(regs.screen_height);
    prod_x     = pkt.dx * $signed({1'b0, regs.motion_gain});
    prod_y     = pkt.dy * $signed({1'b0, regs.motion_gain});
    // y is inverted so that down is positive
    sum_x      = SUM_BITS'($signed({1'b0, pos_x})) + SUM_BITS'(prod_x);
    sum_y      = SUM_BITS'($signed({1'b0, pos_y})) - SUM_BITS'(prod_y);
    pos_x_next = clamp_to(sum_x, lim_x);
    pos_y_next = clamp_to(sum_y, lim_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos_x     <= COORD_BITS'(ps2mc_pkg::POS_X_RESET);
      pos_y     <= COORD_BITS'(ps2mc_pkg::POS_Y_RESET);
    end else if (take) begin
      out_valid <= pkt.valid;
      if (pkt.valid) begin
        pos_x <= pos_x_next;
        pos_y <= pos_y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pkt.valid) begin
      buttons <= pkt.buttons;
    end
  end

  // position only moves when a new result is loaded, so it doubles as the payload
  assign res.valid    = out_valid;
  assign res.cursor_x = pos_x;
  assign res.cursor_y = pos_y;
  assign res.buttons  = buttons;

endmodule
`default_nettype wire

[design/ps2mc_cursor_core.sv]
// No modules; the cursor datapath is in ps2mc_cursor.sv.
`default_nettype none
`default_nettype wire

[tb/sv/tb_ps2_mouse_packet_cursor_core.sv]
// Testbench for the PS/2 mouse packet cursor core: random bytes checked against a cursor tracker.
module tb_ps2_mouse_packet_cursor_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = ps2mc_pkg::COORD_BITS_DEF;

  typedef enum logic [1:0] {FR_HEADER, FR_X, FR_Y} frame_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [2:0]    btn;
  } cursor_t;

  logic clk = 1'b0;
  logic rst;

  ps2mc_byte_if                     rx_ch ();
  ps2mc_cursor_if #(.COORD_BITS(CW)) res_ch ();
  ps2mc_cfg_if                      cfg_ch ();

  ps2_mouse_packet_cursor_core #(.COORD_BITS(CW)) u_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cursor tracker state
  logic [ps2mc_pkg::SIZE_BITS-1:0] size_w = ps2mc_pkg::SCREEN_WIDTH_RESET;
  logic [ps2mc_pkg::SIZE_BITS-1:0] size_h = ps2mc_pkg::SCREEN_HEIGHT_RESET;
  logic [ps2mc_pkg::GAIN_BITS-1:0] gain   = ps2mc_pkg::MOTION_GAIN_RESET;
  frame_t                          frame_pos = FR_HEADER;
  logic [7:0]                      hdr_byte = '0;
  logic [7:0]                      x_byte = '0;
  int                              pos_x = ps2mc_pkg::POS_X_RESET;
  int                              pos_y = ps2mc_pkg::POS_Y_RESET;

  logic [7:0] mouse_bytes [$];
  cursor_t    cursor_expected [$];
  int         mismatches = 0;

  // Zero size acts as one, sizes past the coordinate range saturate.
  function automatic int clamp_axis(int v, logic [ps2mc_pkg::SIZE_BITS-1:0] size);
    int lim;
    lim = (size == 0) ? 0 : int'(size) - 1;
    if (lim > (1 << CW) - 1) lim = (1 << CW) - 1;
    if (v < 0) return 0;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void track_byte(logic [7:0] b);
    int      dx;
    int      dy;
    cursor_t c;
    if (frame_pos == FR_X) begin
      x_byte = b;
      frame_pos = FR_Y;
      return;
    end
    if (frame_pos != FR_Y) begin
      if ((b & ps2mc_pkg::HDR_SYNC) != 0) begin
        hdr_byte = b;
        frame_pos = FR_X;
      end else begin
        frame_pos = FR_HEADER;
      end
      return;
    end
    frame_pos = FR_HEADER;
    if ((hdr_byte & ps2mc_pkg::HDR_OVF) != 0) return;
    dx = int'(x_byte) - (((hdr_byte & ps2mc_pkg::HDR_XSIGN) != 0) ? 256 : 0);
    dy = int'(b) - (((hdr_byte & ps2mc_pkg::HDR_YSIGN) != 0) ? 256 : 0);
    pos_x = clamp_axis(pos_x + dx * int'(gain), size_w);
    pos_y = clamp_axis(pos_y - dy * int'(gain), size_h);
    c.x = pos_x[CW-1:0];
    c.y = pos_y[CW-1:0];
    c.btn = hdr_byte[2:0];
    cursor_expected.push_back(c);
  endfunction

  // Byte driver: bursts of transfers separated by random gaps
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        track_byte(rx_ch.rx_byte);
        void'(mouse_bytes.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = 1;
            2: gap_left = $urandom_range(2, 4);
            default: gap_left = $urandom_range(5, 12);
          endcase
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 8);
        end
      end
      // an offered byte stays put until it transfers
      if (!(rx_ch.valid && !rx_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (mouse_bytes.size() != 0) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= mouse_bytes[0];
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  int      results_seen;
  int      hold_left;
  int      stall_mode;
  int      sink_cycle;
  cursor_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      results_seen = 0;
      hold_left = 0;
      stall_mode = 0;
      sink_cycle = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (cursor_expected.size() == 0) begin
          $error("unexpected cursor result x=%0d y=%0d buttons=%0d",
                 res_ch.cursor_x, res_ch.cursor_y, res_ch.buttons);
          mismatches++;
        end else begin
          want = cursor_expected.pop_front();
          if (res_ch.cursor_x !== want.x) begin
            $error("cursor_x expected %0d, got %0d", want.x, res_ch.cursor_x);
            mismatches++;
          end
          if (res_ch.cursor_y !== want.y) begin
            $error("cursor_y expected %0d, got %0d", want.y, res_ch.cursor_y);
            mismatches++;
          end
          if (res_ch.buttons !== want.btn) begin
            $error("buttons expected %0d, got %0d", want.btn, res_ch.buttons);
            mismatches++;
          end
        end
        // long hold-off so the core backs up into its byte input
        if (results_seen % 200 == 40) hold_left = $urandom_range(150, 250);
      end
      sink_cycle++;
      if (sink_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom_range(0, 1));
          2: res_ch.ready <= ((sink_cycle % 4) < 2);
          default: res_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus helpers
  function automatic int pick_delta();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 511) - 256;
    return $urandom_range(0, 24) - 12;
  endfunction

  task automatic add_packet(input bit ovf, input bit truncated);
    int         dx;
    int         dy;
    logic [7:0] hdr;
    dx = pick_delta();
    dy = pick_delta();
    hdr = 8'($urandom_range(0, 7)) | ps2mc_pkg::HDR_SYNC;
    if (dx < 0) hdr = hdr | ps2mc_pkg::HDR_XSIGN;
    if (dy < 0) hdr = hdr | ps2mc_pkg::HDR_YSIGN;
    if (ovf) hdr = hdr | (ps2mc_pkg::HDR_OVF & 8'($urandom_range(64, 255)));
    mouse_bytes.push_back(hdr);
    mouse_bytes.push_back(8'(dx));
    if (!truncated) mouse_bytes.push_back(8'(dy));
  endtask

  task automatic drain();
    while (mouse_bytes.size() != 0 || rx_ch.valid || cursor_expected.size() != 0)
      @(posedge clk);
    // trailing bytes of a dropped packet may still be inside the core
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ps2mc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [ps2mc_pkg::SIZE_BITS-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ps2mc_pkg::REG_SCREEN_WIDTH:  size_w = val;
      ps2mc_pkg::REG_SCREEN_HEIGHT: size_h = val;
      ps2mc_pkg::REG_MOTION_GAIN:   gain = val[ps2mc_pkg::GAIN_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [ps2mc_pkg::SIZE_BITS-1:0] w,
                              input logic [ps2mc_pkg::SIZE_BITS-1:0] h,
                              input logic [ps2mc_pkg::GAIN_BITS-1:0] g);
    write_reg(ps2mc_pkg::REG_SCREEN_WIDTH, w);
    write_reg(ps2mc_pkg::REG_SCREEN_HEIGHT, h);
    write_reg(ps2mc_pkg::REG_MOTION_GAIN, ps2mc_pkg::SIZE_BITS'(g));
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int n;
    int r;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ps2mc_pkg::REG_SCREEN_WIDTH;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset settings: bytes without sync, delta extremes, overflow drops
    mouse_bytes = '{8'h00, 8'hF7,
                    8'h0F, 8'h00, 8'h00,
                    8'h18, 8'h00, 8'h00,
                    8'h08, 8'hFF, 8'hFF,
                    8'h28, 8'h00, 8'h00,
                    8'h3A, 8'hFF, 8'hFF,
                    8'h48, 8'h7F, 8'h7F,
                    8'hFF, 8'h80, 8'h80,
                    8'h09, 8'h00, 8'h00};
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p)
        0: program_regs(13'd1, 13'd1, 4'd1);
        1: program_regs(13'd4096, 13'd4096, 4'd8);
        2: program_regs(13'd0, 13'd0, 4'd0);
        3: program_regs(13'd8191, 13'd5000, 4'd15);
        4: program_regs(13'd64, 13'd48, 4'd3);
        default: program_regs(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                              4'($urandom_range(1, 8)));
      endcase
      n = 0;
      while (n < 180) begin
        r = $urandom_range(0, 19);
        if (r < 15) begin
          add_packet(1'b0, 1'b0);
          n += 3;
        end else if (r == 15) begin
          add_packet(1'b1, 1'b0);
          n += 3;
        end else if (r < 18) begin
          mouse_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          add_packet(1'b0, 1'b1);
          n += 2;
        end
      end
      drain();
    end

    if (mismatches == 0)
      $display("tb_ps2_mouse_packet_cursor_core OK");
    else
      $display("tb_ps2_mouse_packet_cursor_core NOT OK");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_ps2_mouse_packet_cursor_core NOT OK");
    $finish;
  end

endmodule
